FILE: src/gmc_pkg.sv
// ---------------------------------------------------------------------------
// Global minimum cut package
// Shared constants, sequencer codes and saturating arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

package gmc_pkg;

	// Saturation value for merged weights and phase keys.
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	// Width of the vertex count register.
	localparam int VCOUNT_BITS = 7;

	// Register index, taken from the word address bit.
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// Sequencer state codes.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_PHASE = 3'd3;
	localparam logic [2:0] ST_PASS  = 3'd4;
	localparam logic [2:0] ST_CUT   = 3'd5;
	localparam logic [2:0] ST_MERGE = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	// Add two weights, clamping at the maximum instead of wrapping.
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[32] ? SAT32 : s[31:0];
	endfunction

endpackage

`default_nettype wire

FILE: src/global_min_cut_top.sv
// ---------------------------------------------------------------------------
// Global minimum cut (Stoer-Wagner)
// Loads a weighted adjacency matrix and reports the minimum cut and its side.
// ---------------------------------------------------------------------------
// Usage:
// Matrix entries arrive on the item channel (row, col, weight, present,
// last), one per cycle while the block is loading. Each entry is stored
// once, in the upper triangle of a single synchronous matrix memory.
// An entry with last set starts the computation. Each phase walks the
// matrix row of the newest vertex once per added vertex, with keys kept
// in a small key memory; the merge is one more pass with two read ports.
// The result (cut_weight, side_mask) sits in an output register until the
// receiver takes it; a stalled result holds while the matrix is cleared.
// After reset and after each result the matrix memory is cleared by a pass
// that writes every address; no item is taken during the pass, configuration
// writes are taken always. vertex_count is written over the APB port; the user
// must write it only while the block is idle, the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module global_min_cut_top
	import gmc_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Item channel.
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [5:0]  row,
	input  wire logic [5:0]  col,
	input  wire logic [15:0] weight,
	input  wire logic        present,
	input  wire logic        last,
	// Result channel.
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic      [31:0] cut_weight,
	output logic      [63:0] side_mask
);

	localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int KDEPTH = 1 << VW;

	// Upper-triangle address of a vertex pair.
	function automatic logic [AW-1:0] canon(input logic [VW-1:0] a, input logic [VW-1:0] b);
		canon = (a < b) ? {a, b} : {b, a};
	endfunction

	logic [2:0]             state_q;
	logic [VCOUNT_BITS-1:0] vcount_q;
	logic [AW-1:0]          clr_q;

	logic [31:0]   mat_mem [DEPTH];
	logic [31:0]   rd_a_q, rd_b_q;
	logic          mat_we;
	logic [AW-1:0] mat_waddr, mat_ra, mat_rb;
	logic [31:0]   mat_wdata;

	logic [31:0]   key_mem [KDEPTH];
	logic [31:0]   key_rd_q;
	logic          key_we;
	logic [31:0]   new_key;

	logic [CW-1:0]           n_q, remaining_q, step_q, t_q, n_next;
	logic [MAX_VERTICES-1:0] alive_q, added_q;
	logic [VW-1:0]           rep_q [MAX_VERTICES];
	logic [VW-1:0]           prev_q, lastv_q, pick_q;
	logic [31:0]             phase_key_q;
	logic                    found_q, first_q;
	logic                    s1_valid;
	logic [VW-1:0]           t_s1;
	logic [31:0]             best_cut_q;
	logic [63:0]             best_mask_q;
	logic                    res_valid_q;
	logic [31:0]             res_cut_q;
	logic [63:0]             res_mask_q;

	logic          item_acc, entry_ok, issue, cand_s1, pass_end;
	logic [VW-1:0] t_idx;
	logic [31:0]   entry_val;
	logic [63:0]   group_mask;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_BITS'(2);
		end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
			vcount_q <= pwdata[VCOUNT_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vcount_q) : 32'd0;

	// Handshakes and entry decode.
	assign item_stall   = (state_q != ST_LOAD);
	assign item_acc     = item_valid && !item_stall;
	assign entry_ok     = ({1'b0, row} < 7'(MAX_VERTICES)) && ({1'b0, col} < 7'(MAX_VERTICES))
	                      && (row != col);
	assign entry_val    = present ? 32'(weight[WEIGHT_BITS-1:0]) : 32'd0;
	assign result_valid = res_valid_q;
	assign cut_weight   = res_cut_q;
	assign side_mask    = res_mask_q;

	// Clamped vertex count.
	always_comb begin
		if (vcount_q < VCOUNT_BITS'(2)) begin
			n_next = CW'(2);
		end else if (vcount_q > VCOUNT_BITS'(MAX_VERTICES)) begin
			n_next = CW'(MAX_VERTICES);
		end else begin
			n_next = CW'(vcount_q);
		end
	end

	// Group of the newest vertex as a vertex mask.
	always_comb begin
		group_mask = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			group_mask[i] = (rep_q[i] == lastv_q);
		end
	end

	// Pass control and memory port selection.
	assign t_idx    = t_q[VW-1:0];
	assign issue    = (state_q == ST_PASS || state_q == ST_MERGE) && (t_q < n_q);
	assign pass_end = (t_q == n_q) && !s1_valid;
	assign mat_ra   = canon(prev_q, t_idx);
	assign mat_rb   = canon(lastv_q, t_idx);
	assign cand_s1  = alive_q[t_s1] && !added_q[t_s1];
	assign new_key  = first_q ? rd_b_q : sat_add(key_rd_q, rd_b_q);
	assign key_we   = (state_q == ST_PASS) && s1_valid && cand_s1;

	always_comb begin
		mat_we    = 1'b0;
		mat_waddr = clr_q;
		mat_wdata = 32'd0;
		case (state_q)
			ST_CLEAR: begin
				mat_we = 1'b1;
			end
			ST_LOAD: begin
				mat_we    = item_acc && entry_ok;
				mat_waddr = canon(row[VW-1:0], col[VW-1:0]);
				mat_wdata = entry_val;
			end
			ST_MERGE: begin
				mat_we    = s1_valid && alive_q[t_s1] && t_s1 != prev_q && t_s1 != lastv_q;
				mat_waddr = canon(prev_q, t_s1);
				mat_wdata = sat_add(rd_a_q, rd_b_q);
			end
			default: begin
				mat_we = 1'b0;
			end
		endcase
	end

	// Matrix memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_waddr] <= mat_wdata;
		end
		rd_a_q <= mat_mem[mat_ra];
		rd_b_q <= mat_mem[mat_rb];
	end

	// Phase key memory.
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[t_s1] <= new_key;
		end
		key_rd_q <= key_mem[t_idx];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			n_q         <= CW'(2);
			remaining_q <= '0;
			step_q      <= '0;
			t_q         <= '0;
			alive_q     <= '0;
			added_q     <= '0;
			for (int i = 0; i < MAX_VERTICES; i++) rep_q[i] <= VW'(i);
			prev_q      <= '0;
			lastv_q     <= '0;
			pick_q      <= '0;
			phase_key_q <= '0;
			found_q     <= 1'b0;
			first_q     <= 1'b0;
			s1_valid    <= 1'b0;
			t_s1        <= '0;
			best_cut_q  <= SAT32;
			best_mask_q <= '0;
			res_valid_q <= 1'b0;
			res_cut_q   <= '0;
			res_mask_q  <= '0;
		end else begin
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end

			s1_valid <= issue;
			t_s1     <= t_idx;
			if (issue) begin
				t_q <= t_q + CW'(1);
			end

			// Key pass: running maximum, lowest index wins ties.
			if (state_q == ST_PASS && s1_valid && cand_s1
			    && (!found_q || new_key > phase_key_q)) begin
				pick_q      <= t_s1;
				phase_key_q <= new_key;
				found_q     <= 1'b1;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (item_acc && last) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					n_q         <= n_next;
					remaining_q <= n_next;
					for (int i = 0; i < MAX_VERTICES; i++) begin
						alive_q[i] <= (CW'(i) < n_next);
						rep_q[i]   <= VW'(i);
					end
					best_cut_q  <= SAT32;
					best_mask_q <= '0;
					state_q     <= ST_PHASE;
				end
				ST_PHASE: begin
					// Vertex 0 always stays alive and starts every phase.
					added_q    <= MAX_VERTICES'(1);
					prev_q     <= '0;
					lastv_q    <= '0;
					first_q    <= 1'b1;
					found_q    <= 1'b0;
					step_q     <= CW'(1);
					t_q        <= '0;
					state_q    <= ST_PASS;
				end
				ST_PASS: begin
					if (pass_end) begin
						added_q[pick_q] <= 1'b1;
						prev_q          <= lastv_q;
						lastv_q         <= pick_q;
						step_q          <= step_q + CW'(1);
						first_q         <= 1'b0;
						found_q         <= 1'b0;
						t_q             <= '0;
						if ((step_q + CW'(1)) < remaining_q) begin
							state_q <= ST_PASS;
						end else begin
							state_q <= ST_CUT;
						end
					end
				end
				ST_CUT: begin
					if (phase_key_q < best_cut_q) begin
						best_cut_q  <= phase_key_q;
						best_mask_q <= group_mask;
					end
					t_q     <= '0;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (pass_end) begin
						for (int i = 0; i < MAX_VERTICES; i++) begin
							if (rep_q[i] == lastv_q) rep_q[i] <= prev_q;
						end
						alive_q[lastv_q] <= 1'b0;
						remaining_q      <= remaining_q - CW'(1);
						if ((remaining_q - CW'(1)) > CW'(1)) begin
							state_q <= ST_PHASE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						res_cut_q   <= best_cut_q;
						res_mask_q  <= best_mask_q;
						clr_q       <= '0;
						state_q     <= ST_CLEAR;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A new result is only loaded from the final state.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the final state");

	// Keys are never rewritten for a vertex already in the set.
	a_key_not_added: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> !added_q[t_s1])
		else $error("key written for an added vertex");

	// A merge never writes the two merged vertices' own pair.
	a_merge_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && mat_we) |-> (t_s1 != lastv_q && t_s1 != prev_q))
		else $error("merge wrote a merged vertex entry");

	// A phase only runs while at least two groups remain.
	a_pass_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PASS |-> remaining_q >= CW'(2))
		else $error("phase running with fewer than two groups");
`endif

endmodule

`default_nettype wire
